FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_AT expects i_clk and i_rst_n in the calling scope; ASSERT_AT_RST only i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked during reset too.
`define ASSERT_AT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_AT_RST(lbl, prop, msg)
`endif
`endif

FILE: sv/cbpe_pkg.sv
package cbpe_pkg;

    localparam int COORD_W   = 16;
    localparam int T_W       = 17;
    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = DIFF_W + T_W + 1;
    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int DEPTH     = 7;   // pipeline stages, input register included

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [T_W-1:0]            t_tparam;
    typedef logic signed [PROD_W-1:0]  t_prod;

    localparam t_tparam T_ONE    = t_tparam'(1 << FRAC_BITS);
    localparam t_prod   RND_HALF = t_prod'(1 << (FRAC_BITS - 1));

    typedef t_coord t_ctrl_arr [NUM_REGS];

    // control point defaults: p0 (-200,-200), p1 (-200,200), p2 (200,200), p3 (200,-200)
    localparam t_ctrl_arr CTRL_RESET = '{
        -16'sd3200, -16'sd3200,
        -16'sd3200,  16'sd3200,
         16'sd3200,  16'sd3200,
         16'sd3200, -16'sd3200
    };

endpackage

FILE: sv/cbpe_if.sv
interface cbpe_in_if;
    logic               valid;
    logic               ready;
    cbpe_pkg::t_tparam  t_param;

    modport source (output valid, output t_param, input ready);
    modport sink   (input valid, input t_param, output ready);
endinterface

interface cbpe_out_if;
    logic             valid;
    logic             ready;
    cbpe_pkg::t_coord point_x;
    cbpe_pkg::t_coord point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

FILE: sv/cubic_bezier_point_eval_top.sv
// Cubic Bezier point evaluator, de Casteljau form, Q12.4 points, Q1.16 parameter.
// Pipeline: input register, then two stages per interpolation level: multiply,
// then round and add.
// Throughput: one point per cycle; a stalled output freezes the whole pipeline.
// Reset (sync, active low) clears all stage valid bits and loads the default
// control points; datapath registers are not reset.
`include "assert_macros.svh"

module cubic_bezier_point_eval_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cbpe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cbpe_pkg::COORD_W-1:0]      i_cfg_data,
    cbpe_in_if.sink                           i_in,
    cbpe_out_if.source                        o_out
);

    localparam int LAST = cbpe_pkg::DEPTH - 1;

    // ---------------------------------------------------------------
    // Control point registers: even index is x, odd index is y.
    // Writes beyond the register list are dropped.
    // ---------------------------------------------------------------
    cbpe_pkg::t_coord r_ctrl [cbpe_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= cbpe_pkg::CTRL_RESET;
        end else if (i_cfg_we && (i_cfg_idx < cbpe_pkg::CFG_IDX_W'(cbpe_pkg::NUM_REGS))) begin
            r_ctrl[i_cfg_idx[$clog2(cbpe_pkg::NUM_REGS)-1:0]] <= cbpe_pkg::t_coord'(i_cfg_data);
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: one enable for every stage. The pipeline moves
    // whenever the output slot is empty or being drained this cycle.
    // ---------------------------------------------------------------
    logic                 w_en;
    logic [LAST:0]        r_vld;
    cbpe_pkg::t_tparam    n_t;
    cbpe_pkg::t_tparam    r_tpipe [5];   // t aligned to each level's multiply stage

    assign w_en       = !r_vld[LAST] || o_out.ready;
    assign i_in.ready = w_en;

    // parameters above one saturate to one
    assign n_t = i_in.t_param[cbpe_pkg::T_W-1] ? cbpe_pkg::T_ONE : i_in.t_param;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tpipe[0] <= n_t;
            for (int k = 1; k < 5; k++) begin
                r_tpipe[k] <= r_tpipe[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Three interpolation levels, x and y side by side.
    // Level 1 reads the control points directly: the user must change them only while idle; not enforced.
    // ---------------------------------------------------------------
    cbpe_pkg::t_coord w_l1_x [3];
    cbpe_pkg::t_coord w_l1_y [3];
    cbpe_pkg::t_coord w_l2_x [2];
    cbpe_pkg::t_coord w_l2_y [2];
    cbpe_pkg::t_coord w_l3_x;
    cbpe_pkg::t_coord w_l3_y;

    for (genvar g = 0; g < 3; g++) begin : g_l1
        cbpe_lerp u_x (
            .i_clk (i_clk), .i_en (w_en),
            .i_a (r_ctrl[2*g]), .i_b (r_ctrl[2*g+2]),
            .i_t (r_tpipe[0]), .o_y (w_l1_x[g])
        );
        cbpe_lerp u_y (
            .i_clk (i_clk), .i_en (w_en),
            .i_a (r_ctrl[2*g+1]), .i_b (r_ctrl[2*g+3]),
            .i_t (r_tpipe[0]), .o_y (w_l1_y[g])
        );
    end

    for (genvar g = 0; g < 2; g++) begin : g_l2
        cbpe_lerp u_x (
            .i_clk (i_clk), .i_en (w_en),
            .i_a (w_l1_x[g]), .i_b (w_l1_x[g+1]),
            .i_t (r_tpipe[2]), .o_y (w_l2_x[g])
        );
        cbpe_lerp u_y (
            .i_clk (i_clk), .i_en (w_en),
            .i_a (w_l1_y[g]), .i_b (w_l1_y[g+1]),
            .i_t (r_tpipe[2]), .o_y (w_l2_y[g])
        );
    end

    cbpe_lerp u_l3_x (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_l2_x[0]), .i_b (w_l2_x[1]),
        .i_t (r_tpipe[4]), .o_y (w_l3_x)
    );
    cbpe_lerp u_l3_y (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_l2_y[0]), .i_b (w_l2_y[1]),
        .i_t (r_tpipe[4]), .o_y (w_l3_y)
    );

    // final level output register doubles as the output slot
    assign o_out.valid   = r_vld[LAST];
    assign o_out.point_x = w_l3_x;
    assign o_out.point_y = w_l3_y;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_AT_RST(a_rst_clears_vld, !i_rst_n |=> (r_vld == '0), "valid bits not cleared by reset")
    `ASSERT_AT(a_stage_advance, (r_vld[0] && w_en) |=> r_vld[1], "item lost between stages")
    `ASSERT_AT(a_t_saturated, r_vld[0] |-> (r_tpipe[0] <= cbpe_pkg::T_ONE), "t above one in pipe")
    `ASSERT_AT(a_stall_holds_t, !w_en |=> $stable(r_tpipe[4]), "stage moved during stall")

endmodule

FILE: sv/cbpe_lerp.sv
// y = a + floor(((b - a) * t + half) / 2^16), two register stages.
module cbpe_lerp (
    input  logic              i_clk,
    input  logic              i_en,
    input  cbpe_pkg::t_coord  i_a,
    input  cbpe_pkg::t_coord  i_b,
    input  cbpe_pkg::t_tparam i_t,
    output cbpe_pkg::t_coord  o_y
);

    logic signed [cbpe_pkg::DIFF_W-1:0] w_diff;
    cbpe_pkg::t_prod                    n_prod;
    cbpe_pkg::t_prod                    r_prod;
    cbpe_pkg::t_coord                   r_a;
    cbpe_pkg::t_prod                    w_rnd;
    cbpe_pkg::t_coord                   n_y;
    cbpe_pkg::t_coord                   r_y;

    assign w_diff = $signed({i_b[cbpe_pkg::COORD_W-1], i_b})
                  - $signed({i_a[cbpe_pkg::COORD_W-1], i_a});
    assign n_prod = cbpe_pkg::t_prod'(w_diff * $signed({1'b0, i_t}));

    // arithmetic shift gives floor; the sum fits 16 bits since it stays between a and b
    assign w_rnd = (r_prod + cbpe_pkg::RND_HALF) >>> cbpe_pkg::FRAC_BITS;
    assign n_y   = cbpe_pkg::t_coord'(r_a + w_rnd[cbpe_pkg::COORD_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_a    <= i_a;
            r_y    <= n_y;
        end
    end

    assign o_y = r_y;

endmodule
